@@ src/glw_pkg.sv @@
// Shared types and constants for the greedy line wrapper.
// Holds the input and output word structs and the line store slot layout.
// No dependencies.
package glw_pkg;

    localparam int unsigned MAX_LINE_CELLS = 256;
    localparam int unsigned SLOT_AW        = $clog2(MAX_LINE_CELLS);

    localparam logic [7:0] DEFAULT_TAB     = 8'd8;
    localparam logic [8:0] RST_LINE_WIDTH  = 9'd80;
    localparam logic [7:0] RST_TAB_STOP    = 8'd8;

    localparam logic [1:0] CFG_LINE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_FIRST_IND   = 2'd1;
    localparam logic [1:0] CFG_HANG_IND    = 2'd2;
    localparam logic [1:0] CFG_TAB_STOP    = 2'd3;

    localparam logic REQ_CLUSTER = 1'b0;
    localparam logic REQ_END     = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [31:0] src_offset;
        logic [7:0]  byte_length;
        logic [3:0]  cell_width;
        logic        break_before;
        logic        is_space;
        logic        is_tab;
        logic        is_newline;
    } t_in_word;

    typedef struct packed {
        logic [31:0] line_first_byte;
        logic [31:0] line_end_byte;
        logic [8:0]  cluster_count;
        logic [8:0]  line_cells;
        logic [7:0]  line_indent;
        logic        hard_end;
        logic        last_of_run;
    } t_out_word;

    typedef struct packed {
        logic [31:0] offset;
        logic [7:0]  bytes;
        logic [3:0]  cells;
        logic        is_space;
    } t_slot;

endpackage

@@ src/greedy_line_wrapper_top.sv @@
// Greedy line wrapper: packs grapheme cluster words into lines of the configured width.
// Sequencer over a line store with one write and one read port; uses glw_pkg for word
// types and constants. A non-space cluster that simply appends passes from decode
// through the check and place states to done. A line cut walks the line store slot by
// slot, an address state and a data state per slot (trailing-space trim, break search
// and the line record sum over all kept slots); a cut at a break can walk the search,
// the first record, a trim and the second record. A tab divides the filled cells by the
// tab width for the stop remainder and then expands one cell per cycle. The store is one
// memory with a registered read port; it needs no clearing pass after reset. The input
// stalls while a word is in work; up to two line words per input word leave through an
// output register, the last flagged last_of_run.
module greedy_line_wrapper_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  glw_pkg::t_in_word   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output glw_pkg::t_out_word  o_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE, S_DECODE, S_DIV, S_TAB, S_TRIM_A, S_TRIM_D, S_TRIM_END,
        S_HS_A, S_HS_D, S_HS_END, S_PUT_A, S_PUT_D, S_PUT_FIN,
        S_CHECK1, S_CHECK2, S_PLACE, S_RESTART, S_DONE
    } t_state;

    typedef enum logic [2:0] {
        NX_DONE, NX_CHECK1, NX_CUT, NX_PLACE, NX_RESTART
    } t_next;

    localparam logic [8:0] MAX_W = 9'(glw_pkg::MAX_LINE_CELLS);

    function automatic logic [8:0] f_eff(input logic [8:0] w);
        return (w > MAX_W) ? MAX_W : w;
    endfunction

    function automatic logic [7:0] f_clamp(input logic [7:0] ind, input logic [8:0] w);
        if (w != 9'd0 && {1'b0, ind} >= w) begin
            return 8'(w - 9'd1);
        end
        return ind;
    endfunction

    // slot store
    glw_pkg::t_slot r_mem [glw_pkg::MAX_LINE_CELLS];
    glw_pkg::t_slot r_rd;
    logic [glw_pkg::SLOT_AW-1:0] s_raddr, s_waddr;
    logic           s_we;
    glw_pkg::t_slot s_wdata;

    always_ff @(posedge i_clk) begin
        if (s_we) begin
            r_mem[s_waddr] <= s_wdata;
        end
        r_rd <= r_mem[s_raddr];
    end

    t_state r_state, n_state;
    t_next  r_next, n_next;
    glw_pkg::t_in_word r_in, n_in;
    logic [8:0] r_width, n_width;
    logic [7:0] r_find, n_find, r_hind, n_hind, r_tab, n_tab;
    logic [7:0] r_head, n_head;
    logic [8:0] r_fill, n_fill, r_fcells, n_fcells, r_bp, n_bp;
    logic [7:0] r_ind, n_ind;
    logic       r_drop, n_drop, r_pend, n_pend, r_any, n_any;
    logic [8:0] r_k, n_k, r_put_head, n_put_head, r_put_keep, n_put_keep;
    logic       r_put_hard, n_put_hard;
    logic [8:0] r_sum_head, n_sum_head, r_sum_all, n_sum_all;
    logic [31:0] r_first, n_first, r_end, n_end;
    logic [7:0] r_rem, n_rem, r_stop, n_stop;
    logic [3:0] r_div_i, n_div_i;
    logic       r_ov, n_ov, r_stg_v, n_stg_v;
    glw_pkg::t_out_word r_out, n_out, r_stg, n_stg;

    logic [8:0] s_effw, s_avail;
    logic [9:0] s_need;
    logic       s_nothing, s_free, s_over;
    logic [7:0] s_tw;
    logic [8:0] s_div_t;
    glw_pkg::t_out_word s_rec;

    assign s_effw    = f_eff(r_width);
    assign s_nothing = (s_effw == 9'd0);
    assign s_avail   = s_nothing ? 9'd0 : s_effw - {1'b0, r_ind};
    assign s_need    = {1'b0, r_fcells} + 10'(r_in.cell_width);
    assign s_over    = (s_need > {1'b0, s_avail}) && (r_fill != 9'd0);
    assign s_free    = !r_ov || !i_out_stall;
    assign s_tw      = (r_tab == 8'd0) ? glw_pkg::DEFAULT_TAB : r_tab;
    assign s_div_t   = {r_rem, r_fcells[r_div_i]};

    assign s_waddr = r_head + r_fill[7:0];

    always_comb begin
        case (r_state)
            S_TRIM_A: s_raddr = r_head + 8'(r_fill - 9'd1);
            S_HS_A:   s_raddr = r_head + 8'(r_k - 9'd1);
            default:  s_raddr = r_head + r_k[7:0];
        endcase
    end

    always_comb begin
        s_rec.line_first_byte = (r_put_head == 9'd0) ? 32'd0 : r_first;
        s_rec.line_end_byte   = (r_put_head == 9'd0) ? 32'd0 : r_end;
        s_rec.cluster_count   = r_put_head;
        s_rec.line_cells      = (r_put_keep == 9'd0) ? 9'd0 : r_sum_head;
        s_rec.line_indent     = r_ind;
        s_rec.hard_end        = r_put_hard;
        s_rec.last_of_run     = 1'b0;
    end

    always_comb begin
        n_state = r_state;   n_next = r_next;     n_in = r_in;
        n_width = r_width;   n_find = r_find;     n_hind = r_hind;   n_tab = r_tab;
        n_head = r_head;     n_fill = r_fill;     n_fcells = r_fcells; n_bp = r_bp;
        n_ind = r_ind;       n_drop = r_drop;     n_pend = r_pend;   n_any = r_any;
        n_k = r_k;           n_put_head = r_put_head; n_put_keep = r_put_keep;
        n_put_hard = r_put_hard;
        n_sum_head = r_sum_head; n_sum_all = r_sum_all;
        n_first = r_first;   n_end = r_end;
        n_rem = r_rem;       n_stop = r_stop;     n_div_i = r_div_i;
        n_ov = r_ov & i_out_stall;
        n_out = r_out;       n_stg = r_stg;       n_stg_v = r_stg_v;
        s_we = 1'b0;
        s_wdata.offset   = r_in.src_offset;
        s_wdata.bytes    = r_in.byte_length;
        s_wdata.cells    = r_in.is_tab ? 4'd1 : r_in.cell_width;
        s_wdata.is_space = 1'b1;

        case (r_state)
            S_IDLE: begin
                if (i_cfg_we) begin
                    case (i_cfg_index)
                        glw_pkg::CFG_LINE_WIDTH: n_width = i_cfg_data;
                        glw_pkg::CFG_FIRST_IND:  n_find  = i_cfg_data[7:0];
                        glw_pkg::CFG_HANG_IND:   n_hind  = i_cfg_data[7:0];
                        glw_pkg::CFG_TAB_STOP:   n_tab   = i_cfg_data[7:0];
                        default: ;
                    endcase
                    n_ind = f_clamp(r_any ? n_hind : n_find, f_eff(n_width));
                end
                if (i_in_valid) begin
                    n_in    = i_in_data;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                n_k = 9'd0;
                if (r_in.req_type == glw_pkg::REQ_END) begin
                    if (r_pend || !r_any) begin
                        n_put_head = r_fill; n_put_keep = r_fill; n_put_hard = 1'b1;
                        n_next = NX_RESTART; n_state = S_PUT_A;
                    end else begin
                        n_state = S_RESTART;
                    end
                end else if (r_in.is_newline) begin
                    n_put_head = r_fill; n_put_keep = r_fill; n_put_hard = 1'b1;
                    n_next = NX_DONE; n_state = S_PUT_A;
                end else begin
                    if (r_in.break_before) n_bp = r_fill;
                    if (r_in.cell_width != 4'd0 || r_in.is_tab || r_in.is_space) begin
                        n_pend = 1'b1;
                    end
                    if (r_in.is_tab) begin
                        if (s_nothing) begin
                            n_state = S_DONE;
                        end else begin
                            n_rem = 8'd0; n_div_i = 4'd8; n_state = S_DIV;
                        end
                    end else if (r_in.cell_width == 4'd0 || s_nothing) begin
                        n_state = S_DONE;
                    end else if (r_in.is_space) begin
                        if (r_drop || s_need > {1'b0, s_avail}) begin
                            n_drop = 1'b1;
                        end else if (!r_fill[8]) begin
                            s_we = 1'b1;
                            n_fill = r_fill + 9'd1;
                            n_fcells = 9'(s_need);
                        end
                        n_state = S_DONE;
                    end else if (r_drop) begin
                        n_next = NX_CHECK1; n_state = S_TRIM_A;
                    end else begin
                        n_state = S_CHECK1;
                    end
                end
            end
            S_DIV: begin
                // one remainder bit per cycle
                n_rem = (s_div_t >= {1'b0, s_tw}) ? 8'(s_div_t - {1'b0, s_tw})
                                                  : s_div_t[7:0];
                if (r_div_i == 4'd0) begin
                    n_stop = s_tw - n_rem; n_k = 9'd0; n_state = S_TAB;
                end else begin
                    n_div_i = r_div_i - 4'd1;
                end
            end
            S_TAB: begin
                if (r_k == {1'b0, r_stop}) begin
                    n_state = S_DONE;
                end else if ({1'b0, r_fcells} + 10'd1 > {1'b0, s_avail}) begin
                    n_drop = 1'b1; n_state = S_DONE;
                end else if (r_drop) begin
                    n_state = S_DONE;
                end else begin
                    if (!r_fill[8]) begin
                        s_we = 1'b1;
                        n_fill = r_fill + 9'd1;
                        n_fcells = r_fcells + 9'd1;
                        n_pend = 1'b1;
                    end
                    n_k = r_k + 9'd1;
                end
            end
            S_TRIM_A: n_state = (r_fill == 9'd0) ? S_TRIM_END : S_TRIM_D;
            S_TRIM_D: begin
                if (r_rd.is_space) begin
                    n_fcells = r_fcells - 9'(r_rd.cells);
                    n_fill = r_fill - 9'd1;
                    n_state = S_TRIM_A;
                end else begin
                    n_state = S_TRIM_END;
                end
            end
            S_TRIM_END: begin
                if (r_bp > r_fill) n_bp = r_fill;
                n_put_head = r_fill; n_put_keep = r_fill; n_put_hard = 1'b0;
                n_k = 9'd0; n_state = S_PUT_A;
            end
            S_HS_A: n_state = (r_k == 9'd0) ? S_HS_END : S_HS_D;
            S_HS_D: begin
                if (r_rd.is_space) begin
                    n_k = r_k - 9'd1; n_state = S_HS_A;
                end else begin
                    n_state = S_HS_END;
                end
            end
            S_HS_END: begin
                n_put_head = r_k; n_put_keep = r_bp; n_put_hard = 1'b0;
                n_next = NX_CUT; n_k = 9'd0; n_state = S_PUT_A;
            end
            S_PUT_A: n_state = (r_k == r_put_keep) ? S_PUT_FIN : S_PUT_D;
            S_PUT_D: begin
                n_sum_all = ((r_k == 9'd0) ? 9'd0 : r_sum_all) + 9'(r_rd.cells);
                n_sum_head = (r_k == 9'd0) ? 9'd0 : r_sum_head;
                if (r_k < r_put_head) n_sum_head = n_sum_head + 9'(r_rd.cells);
                if (r_k == 9'd0) n_first = r_rd.offset;
                if (r_k == r_put_head - 9'd1) n_end = r_rd.offset + 32'(r_rd.bytes);
                n_k = r_k + 9'd1;
                n_state = S_PUT_A;
            end
            S_PUT_FIN: begin
                if (!r_stg_v || s_free) begin
                    if (r_stg_v) begin
                        n_out = r_stg; n_ov = 1'b1;
                    end
                    n_stg = s_rec; n_stg_v = 1'b1;
                    n_head = r_head + r_put_keep[7:0];
                    n_fill = r_fill - r_put_keep;
                    if (r_put_keep != 9'd0) n_fcells = r_fcells - r_sum_all;
                    n_ind = f_clamp(r_hind, s_effw);
                    n_any = 1'b1;
                    n_pend = (n_fill != 9'd0);
                    n_bp = 9'd0;
                    n_drop = 1'b0;
                    case (r_next)
                        NX_CHECK1:  n_state = S_CHECK1;
                        NX_CUT:     n_state = S_CHECK2;
                        NX_PLACE:   n_state = S_PLACE;
                        NX_RESTART: n_state = S_RESTART;
                        default:    n_state = S_DONE;
                    endcase
                end
            end
            S_CHECK1: begin
                if (s_over) begin
                    if (r_bp != 9'd0 && r_bp < r_fill) begin
                        n_k = r_bp; n_state = S_HS_A;
                    end else begin
                        n_next = NX_PLACE; n_state = S_TRIM_A;
                    end
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_CHECK2: begin
                if (r_in.break_before) n_bp = r_fill;
                if (s_over) begin
                    n_next = NX_PLACE; n_state = S_TRIM_A;
                end else begin
                    n_state = S_PLACE;
                end
            end
            S_PLACE: begin
                s_wdata.is_space = 1'b0;
                if (!r_fill[8]) begin
                    s_we = 1'b1;
                    n_fill = r_fill + 9'd1;
                    n_fcells = 9'(s_need);
                    n_pend = 1'b1;
                end
                n_state = S_DONE;
            end
            S_RESTART: begin
                n_head = 8'd0; n_fill = 9'd0; n_fcells = 9'd0; n_bp = 9'd0;
                n_drop = 1'b0; n_pend = 1'b0; n_any = 1'b0;
                n_ind = f_clamp(r_find, s_effw);
                n_state = S_DONE;
            end
            S_DONE: begin
                // release the held line word as the last of this run
                if (!r_stg_v) begin
                    n_state = S_IDLE;
                end else if (s_free) begin
                    n_out = r_stg; n_out.last_of_run = 1'b1; n_ov = 1'b1;
                    n_stg_v = 1'b0; n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;   r_next <= NX_DONE;
            r_width <= glw_pkg::RST_LINE_WIDTH;
            r_find <= 8'd0;      r_hind <= 8'd0;   r_tab <= glw_pkg::RST_TAB_STOP;
            r_head <= 8'd0;      r_fill <= 9'd0;   r_fcells <= 9'd0; r_bp <= 9'd0;
            r_ind <= 8'd0;       r_drop <= 1'b0;   r_pend <= 1'b0;   r_any <= 1'b0;
            r_ov <= 1'b0;        r_stg_v <= 1'b0;
        end else begin
            r_state <= n_state;  r_next <= n_next;
            r_width <= n_width;  r_find <= n_find; r_hind <= n_hind; r_tab <= n_tab;
            r_head <= n_head;    r_fill <= n_fill; r_fcells <= n_fcells; r_bp <= n_bp;
            r_ind <= n_ind;      r_drop <= n_drop; r_pend <= n_pend; r_any <= n_any;
            r_ov <= n_ov;        r_stg_v <= n_stg_v;
        end
        r_in <= n_in;        r_k <= n_k;
        r_put_head <= n_put_head; r_put_keep <= n_put_keep; r_put_hard <= n_put_hard;
        r_sum_head <= n_sum_head; r_sum_all <= n_sum_all;
        r_first <= n_first;  r_end <= n_end;
        r_rem <= n_rem;      r_stop <= n_stop; r_div_i <= n_div_i;
        r_out <= n_out;      r_stg <= n_stg;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ov;
    assign o_out_data  = r_out;

endmodule

@@ tb/glw_checker.sv @@
// Checker for the greedy line wrapper: watches the word channels and the config port.
// Keeps its own line-packing predictor and compares every line word, field by field.
// Depends on glw_pkg.
module glw_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_stall,
    input  glw_pkg::t_in_word   i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_stall,
    input  glw_pkg::t_out_word  i_out_data,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [8:0]          i_cfg_data,
    output int unsigned         o_errors,
    output int unsigned         o_lines_due
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned SLOTS = glw_pkg::MAX_LINE_CELLS;

    int unsigned width_reg, first_reg, hang_reg, tab_reg;
    logic [31:0] s_off [SLOTS];
    logic [7:0]  s_nb [SLOTS];
    int unsigned s_cells [SLOTS];
    bit          s_sp [SLOTS];
    int unsigned head, fill, fcells, cur_ind, brk_at;
    bit          dropping, pending, emitted;
    int unsigned made;
    glw_pkg::t_out_word lines_q[$];

    initial o_errors = 0;

    function automatic int unsigned eff_w();
        return (width_reg > SLOTS) ? SLOTS : width_reg;
    endfunction

    function automatic int unsigned clamp_ind(int unsigned ind);
        if (eff_w() != 0 && ind >= eff_w()) return eff_w() - 1;
        return ind;
    endfunction

    function automatic int unsigned room();
        return (eff_w() == 0) ? 0 : eff_w() - cur_ind;
    endfunction

    function automatic int unsigned slot(int unsigned k);
        return (head + k) % SLOTS;
    endfunction

    task automatic emit_line(int unsigned h, int unsigned keep, bit hard);
        int unsigned cells, dropped, b;
        glw_pkg::t_out_word o;
        cells = 0;
        dropped = 0;
        for (int unsigned k = 0; k < keep && k < fill; k++) begin
            if (k < h) cells += s_cells[slot(k)];
            else dropped += s_cells[slot(k)];
        end
        o = '0;
        if (h > 0) begin
            b = slot(h - 1);
            o.line_first_byte = s_off[slot(0)];
            o.line_end_byte = s_off[b] + {24'd0, s_nb[b]};
        end
        o.cluster_count = h[8:0];
        o.line_cells = cells[8:0];
        o.line_indent = cur_ind[7:0];
        o.hard_end = hard;
        lines_q = {lines_q, o};
        made++;
        head = (head + keep) % SLOTS;
        fill -= keep;
        fcells -= cells + dropped;
        cur_ind = clamp_ind(hang_reg);
        emitted = 1;
        pending = fill > 0;
        brk_at = 0;
        dropping = 0;
    endtask

    task automatic flush_line(bit hard);
        emit_line(fill, fill, hard);
    endtask

    task automatic store(logic [31:0] off, logic [7:0] nb, int unsigned c, bit sp);
        int unsigned p;
        if (fill >= SLOTS) return;
        p = slot(fill);
        s_off[p] = off;
        s_nb[p] = nb;
        s_cells[p] = c;
        s_sp[p] = sp;
        fill++;
        fcells += c;
        pending = 1;
    endtask

    task automatic trim_tail();
        while (fill > 0 && s_sp[slot(fill - 1)]) begin
            fcells -= s_cells[slot(fill - 1)];
            fill--;
        end
        if (brk_at > fill) brk_at = fill;
    endtask

    task automatic restart_text();
        head = 0;
        fill = 0;
        fcells = 0;
        brk_at = 0;
        dropping = 0;
        pending = 0;
        emitted = 0;
        cur_ind = clamp_ind(first_reg);
    endtask

    task automatic pack_cluster(glw_pkg::t_in_word w);
        int unsigned cw, av, tw, stop, h;
        bit none;
        cw = w.cell_width;
        none = eff_w() == 0;
        av = room();
        if (w.is_newline) begin
            flush_line(1);
            return;
        end
        if (w.break_before) brk_at = fill;
        if (cw > 0 || w.is_tab || w.is_space) pending = 1;
        if (w.is_tab) begin
            if (none) return;
            tw = (tab_reg != 0) ? tab_reg : glw_pkg::DEFAULT_TAB;
            stop = tw - (fcells % tw);
            for (int unsigned k = 0; k < stop; k++) begin
                if (fcells + 1 > av) begin
                    dropping = 1;
                    break;
                end
                if (dropping) break;
                store(w.src_offset, w.byte_length, 1, 1);
            end
            return;
        end
        if (cw == 0 || none) return;
        if (w.is_space) begin
            if (dropping || fcells + cw > av) begin
                dropping = 1;
                return;
            end
            store(w.src_offset, w.byte_length, cw, 1);
            return;
        end
        if (dropping) begin
            trim_tail();
            flush_line(0);
            av = room();
        end
        if (fcells + cw > av && fill > 0) begin
            if (brk_at > 0 && brk_at < fill) begin
                h = brk_at;
                while (h > 0 && s_sp[slot(h - 1)]) h--;
                emit_line(h, brk_at, 0);
                av = room();
                if (w.break_before) brk_at = fill;
                if (fcells + cw > av && fill > 0) begin
                    trim_tail();
                    flush_line(0);
                end
            end else begin
                trim_tail();
                flush_line(0);
            end
        end
        store(w.src_offset, w.byte_length, cw, 0);
    endtask

    task automatic predict_lines(glw_pkg::t_in_word w);
        made = 0;
        if (w.req_type == glw_pkg::REQ_END) begin
            if (pending || !emitted) flush_line(1);
            restart_text();
        end else begin
            pack_cluster(w);
        end
        if (made > 0) lines_q[$].last_of_run = 1'b1;
    endtask

    task automatic report(string field, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h, want %0h at %0t", field, got, want, $realtime);
        o_errors++;
    endtask

    task automatic check_field(string field, logic [31:0] got, logic [31:0] want);
        if (got !== want) report(field, got, want);
    endtask

    always @(posedge i_clk) begin
        glw_pkg::t_out_word want;
        if (!i_rst_n) begin
            width_reg = glw_pkg::RST_LINE_WIDTH;
            first_reg = 0;
            hang_reg = 0;
            tab_reg = glw_pkg::RST_TAB_STOP;
            lines_q.delete();
            restart_text();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    glw_pkg::CFG_LINE_WIDTH: width_reg = i_cfg_data;
                    glw_pkg::CFG_FIRST_IND:  first_reg = i_cfg_data[7:0];
                    glw_pkg::CFG_HANG_IND:   hang_reg = i_cfg_data[7:0];
                    glw_pkg::CFG_TAB_STOP:   tab_reg = i_cfg_data[7:0];
                    default: ;
                endcase
                cur_ind = clamp_ind(emitted ? hang_reg : first_reg);
            end
            if (i_in_valid && !i_in_stall) predict_lines(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (lines_q.size() == 0) begin
                    report("unexpected line word", i_out_data.line_first_byte, 32'd0);
                end else begin
                    want = lines_q.pop_front();
                    check_field("line_first_byte", i_out_data.line_first_byte,
                                want.line_first_byte);
                    check_field("line_end_byte", i_out_data.line_end_byte,
                                want.line_end_byte);
                    check_field("cluster_count", i_out_data.cluster_count,
                                want.cluster_count);
                    check_field("line_cells", i_out_data.line_cells, want.line_cells);
                    check_field("line_indent", i_out_data.line_indent, want.line_indent);
                    check_field("hard_end", i_out_data.hard_end, want.hard_end);
                    check_field("last_of_run", i_out_data.last_of_run, want.last_of_run);
                end
            end
        end
        o_lines_due = lines_q.size();
    end

endmodule

@@ tb/greedy_line_wrapper_top_tb.sv @@
// Testbench top for the greedy line wrapper: clock, reset, config phases and word stimulus.
// Instantiates greedy_line_wrapper_top and glw_checker; depends on glw_pkg.
module greedy_line_wrapper_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned ITEMS      = 1850;
    localparam int unsigned SETTLE     = 600;
    localparam int unsigned DOG_LIMIT  = 20000;
    localparam int unsigned NPHASE     = 9;

    logic        i_clk;
    logic        i_rst_n;
    logic        in_valid, in_stall, out_valid, out_stall;
    glw_pkg::t_in_word  in_data;
    glw_pkg::t_out_word out_data;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [8:0]  cfg_data;
    int unsigned errors, lines_due;
    int unsigned sent_n, quiet_cycles;
    int unsigned chars_left;
    logic [31:0] cursor;
    bit          held;
    int unsigned hold_left;

    greedy_line_wrapper_top dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_data(in_data),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    glw_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_data(in_data),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_data(out_data),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_lines_due(lines_due)
    );

    always begin
        i_clk = 1'b1;
        #1;
        i_clk = 1'b0;
        #1;
    end

    function automatic bit calm();
        return sent_n >= 900 && sent_n < 1100;
    endfunction

    // receiver: random stalls, one long hold-off to back the block up
    initial begin
        out_stall = 1'b0;
        held = 0;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (!held && sent_n >= 400) begin
                held = 1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                out_stall = 1'b1;
                hold_left--;
            end else if (calm()) begin
                out_stall = 1'b0;
            end else begin
                out_stall = $urandom_range(99) < 24;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !i_rst_n) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= DOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(glw_pkg::t_in_word w);
        while (!calm() && $urandom_range(99) < 24) begin
            in_valid = 1'b0;
            @(negedge i_clk);
        end
        in_data = w;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall);
        @(negedge i_clk);
        in_valid = 1'b0;
        sent_n++;
    endtask

    function automatic glw_pkg::t_in_word glyph(int unsigned cw, bit brk, bit sp, bit tab,
                                                bit nl);
        glw_pkg::t_in_word w;
        w = '0;
        w.req_type = glw_pkg::REQ_CLUSTER;
        w.src_offset = cursor;
        w.byte_length = 8'($urandom_range(4, 1));
        w.cell_width = 4'(cw);
        w.break_before = brk;
        w.is_space = sp;
        w.is_tab = tab;
        w.is_newline = nl;
        return w;
    endfunction

    task automatic send_glyph(int unsigned cw, bit brk, bit sp, bit tab, bit nl);
        glw_pkg::t_in_word w;
        w = glyph(cw, brk, sp, tab, nl);
        cursor += w.byte_length;
        send_word(w);
    endtask

    task automatic send_end();
        glw_pkg::t_in_word w;
        w = '0;
        w.req_type = glw_pkg::REQ_END;
        send_word(w);
    endtask

    // well-formed text most of the time: words, spaces, tabs, newlines, end marks
    task automatic send_random();
        glw_pkg::t_in_word w;
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8) begin
            w = glw_pkg::t_in_word'(49'({$urandom, $urandom}));
            w.req_type = ($urandom_range(19) == 0) ? glw_pkg::REQ_END : glw_pkg::REQ_CLUSTER;
            send_word(w);
        end else if (chars_left > 0) begin
            chars_left--;
            send_glyph(($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2, 1),
                       $urandom_range(9) == 0, 0, 0, 0);
        end else begin
            r = $urandom_range(99);
            if (r < 55) send_glyph(1, 0, 1, 0, 0);
            else if (r < 63) send_glyph(1, 0, $urandom_range(1) == 1, 1, 0);
            else if (r < 69) send_glyph(1, 0, 0, 0, 1);
            else if (r < 72) send_end();
            chars_left = ($urandom_range(9) == 0) ? $urandom_range(40, 10)
                                                  : $urandom_range(8, 1);
            send_glyph($urandom_range(2, 1), 1, 0, 0, 0);
        end
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] val);
        cfg_index = idx;
        cfg_data = val;
        cfg_we = 1'b1;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    // hold input until every line word is back, let the block finish, then reconfigure
    task automatic reconfigure(logic [8:0] lw, logic [7:0] fi, logic [7:0] hi, logic [7:0] ts);
        while (lines_due != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        write_reg(glw_pkg::CFG_LINE_WIDTH, lw);
        write_reg(glw_pkg::CFG_FIRST_IND, {1'b0, fi});
        write_reg(glw_pkg::CFG_HANG_IND, {1'b0, hi});
        write_reg(glw_pkg::CFG_TAB_STOP, {1'b0, ts});
    endtask

    initial begin
        logic [8:0] widths [NPHASE];
        logic [7:0] firsts [NPHASE];
        logic [7:0] hangs [NPHASE];
        logic [7:0] tabs [NPHASE];
        glw_pkg::t_in_word w;
        widths = '{9'd80, 9'd0, 9'd1, 9'd20, 9'd256, 9'd511, 9'd12, 9'd40, 9'd80};
        firsts = '{8'd0, 8'd5, 8'd0, 8'd4, 8'd255, 8'd10, 8'd0, 8'd39, 8'd2};
        hangs  = '{8'd0, 8'd3, 8'd0, 8'd2, 8'd255, 8'd200, 8'd6, 8'd1, 8'd4};
        tabs   = '{8'd8, 8'd0, 8'd1, 8'd4, 8'd255, 8'd3, 8'd0, 8'd7, 8'd8};
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = glw_pkg::CFG_LINE_WIDTH;
        cfg_data = '0;
        sent_n = 0;
        quiet_cycles = 0;
        chars_left = 0;
        cursor = 32'd100;
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // directed: zero-cell clusters, extremes, flag precedence, empty texts
        send_glyph(0, 1, 0, 0, 0);
        send_glyph(0, 0, 1, 0, 0);
        w = glyph(15, 1, 0, 0, 0);
        w.src_offset = 32'hFFFF_FFFF;
        w.byte_length = 8'hFF;
        send_word(w);
        send_glyph(1, 0, 1, 1, 0);
        send_glyph(1, 0, 1, 1, 1);
        send_end();
        send_end();
        // word longer than the line: hard breaks
        repeat (12) send_glyph(15, 0, 0, 0, 0);
        // spaces overflowing the line, then a visible cluster ends it
        repeat (4) send_glyph(15, 0, 1, 0, 0);
        send_glyph(3, 1, 0, 0, 0);
        send_end();

        for (int p = 0; p < NPHASE; p++) begin
            reconfigure(widths[p], firsts[p], hangs[p], tabs[p]);
            while (sent_n < (p + 1) * ITEMS / NPHASE) send_random();
            send_end();
        end

        while (lines_due != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
        if (errors == 0 && lines_due == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ greedy_line_wrapper_top.f @@
src/glw_pkg.sv
src/greedy_line_wrapper_top.sv
tb/glw_checker.sv
tb/greedy_line_wrapper_top_tb.sv
